### sv/smx_pkg.sv
// Shared types, codes and tables for the six-voice wavetable mixer.
// No dependencies; imported by every module of the block but smx_ram.
package smx_pkg;

	// Voice organisation
	localparam int unsigned VOICES        = 6;
	localparam int unsigned VOICE_AW      = 3;
	localparam int unsigned SQUARE_VOICES = 3;

	// Field and state widths
	localparam int unsigned PHASE_W = 16;
	localparam int unsigned INC_W   = 15;
	localparam int unsigned GAIN_W  = 8;
	localparam int unsigned VOICE_W = INC_W + GAIN_W;
	localparam int unsigned MAG_W   = 23;
	localparam int unsigned PROD_W  = MAG_W + 1;
	localparam int unsigned SUM_W   = 27;
	localparam int unsigned MIX_SHIFT = 11;
	localparam int unsigned SAMPLE_W  = 16;

	// Table constants
	localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(32767);
	localparam int unsigned NOISE_TABLE_SIZE = 256;
	localparam int unsigned NOISE_AW = $clog2(NOISE_TABLE_SIZE);

	// Request action codes
	localparam logic [1:0] ACT_SET_VOICE = 2'd0;
	localparam logic [1:0] ACT_SAMPLE    = 2'd1;
	localparam logic [1:0] ACT_SILENCE   = 2'd2;

	// Noise table sign bits: bit b of word w set when entry 16*w+b is positive
	localparam logic [15:0] NOISE_SIGNS [16] = '{
		16'h0000, 16'h4000, 16'h4444, 16'h6444, 16'h6464, 16'h7464, 16'h7465, 16'h7C65,
		16'h7C65, 16'h3865, 16'h7C21, 16'h3A65, 16'h7C23, 16'h2B65, 16'h7C23, 16'h2BE5
	};

	// Stage tag travelling with the voice sweep
	typedef struct packed {
		logic                vld;
		logic                last;
		logic [VOICE_AW-1:0] idx;
	} stage_t;

	// True when the noise table entry at this index is positive
	function automatic logic noise_positive(input logic [NOISE_AW-1:0] idx);
		logic [15:0] word;
		word = NOISE_SIGNS[idx[7:4]];
		return word[idx[3:0]];
	endfunction

endpackage

### sv/smx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module smx_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/smx_mixer.sv
// Mix datapath: table lookup, gain product and running sum over the voice sweep.
// Depends on smx_pkg.
module smx_mixer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  smx_pkg::stage_t                       st_s1,
	input  logic [smx_pkg::PHASE_W-1:0]           phase_s1,
	input  logic [smx_pkg::GAIN_W-1:0]            gain_s1,
	input  logic                                  out_free,
	output logic                                  finish,
	output logic [smx_pkg::SAMPLE_W-1:0]          mix_sample
);
	import smx_pkg::*;

	logic                     vld_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     hold;
	logic                     negative;
	logic [MAG_W-1:0]         mag;
	logic signed [SUM_W-1:0]  sum_full;

	// Table sign for the voice in stage 1; square table is positive in its lower half
	always_comb begin
		if (st_s1.idx < VOICE_AW'(SQUARE_VOICES)) begin
			negative = phase_s1[13];
		end else begin
			negative = ~noise_positive(phase_s1[PHASE_W-1 -: NOISE_AW]);
		end
		mag = MAG_W'(gain_s1) * FULL_SCALE;
	end

	// Final voice waits here while the output register is still occupied
	assign hold     = vld_s2 & last_s2 & ~out_free;
	assign finish   = vld_s2 & last_s2 & out_free;
	assign sum_full = acc_q + SUM_W'(prod_s2);
	assign mix_sample = sum_full[SUM_W-1 -: SAMPLE_W];

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else if (!hold) begin
			vld_s2  <= st_s1.vld;
			last_s2 <= st_s1.last;
		end
	end

	// Stage 2 product
	always_ff @(posedge clk) begin
		if (!hold) begin
			prod_s2 <= negative ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	// Running sum, cleared as each sample completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (finish) begin
			acc_q <= '0;
		end else if (vld_s2 && !last_s2) begin
			acc_q <= sum_full;
		end
	end

endmodule

### sv/six_voice_wavetable_mixer_top.sv
// Six-voice wavetable mixer, top level.
// Set-voice and silence requests do not hold off the next request; a sample request
// is answered after six voice reads from the state RAMs, one per cycle,
// then product and sum stages, and the next request is taken in the cycle the
// result is registered, so no new request is taken while a sample is in the sweep.
// Asynchronous active-low reset clears phases, gains, increments and play_enable.
module six_voice_wavetable_mixer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic                            cfg_wr_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [1:0]                      action,
	input  logic [2:0]                      channel,
	input  logic [15:0]                     freq_step,
	input  logic [7:0]                      volume,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic signed [15:0]              sample
);
	import smx_pkg::*;

	logic                play_en_q;
	logic                busy_q;
	logic                rd_act_q;
	logic [VOICE_AW-1:0] rd_cnt_q;
	stage_t              st_s1;
	logic [VOICES-1:0]   voice_vld_q;
	logic [VOICES-1:0]   phase_vld_q;
	logic                req_acc;
	logic                start;
	logic                set_wr;
	logic                silence;
	logic                finish;
	logic                out_free;
	logic                rsp_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] mix_sample;
	logic [VOICE_W-1:0]  voice_rd;
	logic [PHASE_W-1:0]  phase_rd;
	logic [PHASE_W-1:0]  phase_s1;
	logic [INC_W-1:0]    inc_s1;
	logic [GAIN_W-1:0]   gain_s1;

	// Request decode
	assign req_stall = busy_q & ~finish;
	assign req_acc   = req_valid & ~req_stall;
	assign start     = req_acc & (action == ACT_SAMPLE) & play_en_q;
	assign set_wr    = req_acc & (action == ACT_SET_VOICE) & (channel < VOICE_AW'(VOICES));
	assign silence   = req_acc & (action == ACT_SILENCE);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			play_en_q <= cfg_wr_data;
		end
	end

	// Voice sweep sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rd_act_q <= 1'b0;
			rd_cnt_q <= '0;
			st_s1    <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (start) begin
				rd_act_q <= 1'b1;
				rd_cnt_q <= '0;
			end else if (rd_act_q) begin
				rd_act_q <= (rd_cnt_q != VOICE_AW'(VOICES - 1));
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			st_s1.vld  <= rd_act_q;
			st_s1.last <= (rd_cnt_q == VOICE_AW'(VOICES - 1));
			st_s1.idx  <= rd_cnt_q;
		end
	end

	// Written flags: silence drops gains and increments, phases stay
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_vld_q <= '0;
			phase_vld_q <= '0;
		end else begin
			if (silence) begin
				voice_vld_q <= '0;
			end else if (set_wr) begin
				voice_vld_q[channel] <= 1'b1;
			end
			if (st_s1.vld) begin
				phase_vld_q[st_s1.idx] <= 1'b1;
			end
		end
	end

	// Gain and increment store
	smx_ram #(
		.WIDTH(VOICE_W),
		.DEPTH(VOICES)
	) u_voice_ram (
		.clk    (clk),
		.wr_en  (set_wr),
		.wr_addr(channel),
		.wr_data({freq_step[15:1], volume}),
		.rd_en  (rd_act_q),
		.rd_addr(rd_cnt_q),
		.rd_data(voice_rd)
	);

	// Phase accumulator store, written back as each voice passes stage 1
	smx_ram #(
		.WIDTH(PHASE_W),
		.DEPTH(VOICES)
	) u_phase_ram (
		.clk    (clk),
		.wr_en  (st_s1.vld),
		.wr_addr(st_s1.idx),
		.wr_data(phase_s1 + PHASE_W'(inc_s1)),
		.rd_en  (rd_act_q),
		.rd_addr(rd_cnt_q),
		.rd_data(phase_rd)
	);

	// Unwritten entries read as zero
	always_comb begin
		phase_s1 = phase_vld_q[st_s1.idx] ? phase_rd : '0;
		if (voice_vld_q[st_s1.idx]) begin
			inc_s1  = voice_rd[VOICE_W-1 -: INC_W];
			gain_s1 = voice_rd[GAIN_W-1:0];
		end else begin
			inc_s1  = '0;
			gain_s1 = '0;
		end
	end

	smx_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.st_s1     (st_s1),
		.phase_s1  (phase_s1),
		.gain_s1   (gain_s1),
		.out_free  (out_free),
		.finish    (finish),
		.mix_sample(mix_sample)
	);

	// Output register
	assign out_free = ~rsp_valid_q | ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			sample_q <= mix_sample;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign sample    = $signed(sample_q);

endmodule

### sv/smx_checker.sv
// Port-level checks for the six-voice wavetable mixer, bound to the top level.
// Depends on smx_pkg.
module smx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic [1:0]  action,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [15:0] sample
);
	import smx_pkg::*;

	// A held result stays valid
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	// A held result keeps its value
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(sample))
		else $error("result changed while stalled");

	// After a set-voice or silence request the block takes requests again in the next cycle
	a_short_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (action == ACT_SET_VOICE || action == ACT_SILENCE)
		|=> !req_stall)
		else $error("block busy after a single-cycle request");

	// A new result only comes out of a sweep that held off requests
	a_rsp_from_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall, 2))
		else $error("result without a voice sweep");

endmodule

bind six_voice_wavetable_mixer_top smx_checker u_smx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.action   (action),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.sample   (sample)
);

### tb/six_voice_wavetable_mixer_checker.sv
// Checker for the six-voice wavetable mixer: watches the register port, the request
// channel and the result channel, predicts each mixed sample and compares it with the block's output.
// Depends on smx_pkg for widths, action codes and the noise sign table.
`timescale 1ns / 100ps

module six_voice_wavetable_mixer_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_wr_data,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic [1:0]                          action,
	input  logic [2:0]                          channel,
	input  logic [15:0]                         freq_step,
	input  logic [7:0]                          volume,
	input  logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  logic signed [smx_pkg::SAMPLE_W-1:0] sample,
	output int                                  mismatch_count,
	output int                                  samples_due
);
	import smx_pkg::*;

	// Shadow copy of the voice state and the enable bit
	logic [PHASE_W-1:0]         voice_phase [VOICES];
	logic [INC_W-1:0]           voice_step  [VOICES];
	logic [GAIN_W-1:0]          voice_gain  [VOICES];
	logic                       play_on;
	logic signed [SAMPLE_W-1:0] due_samples [$];

	// Mix of all six voices at their current phases, floored shift by MIX_SHIFT
	function automatic logic signed [SAMPLE_W-1:0] mix_voices();
		int          acc;
		logic [7:0]  idx;
		logic [15:0] signs;
		logic        positive;
		acc = 0;
		for (int v = 0; v < VOICES; v++) begin
			idx = voice_phase[v][15:8];
			if (v < SQUARE_VOICES) begin
				// square table: first half of 64 entries positive
				positive = !idx[5];
			end else begin
				signs    = NOISE_SIGNS[idx[7:4]];
				positive = signs[idx[3:0]];
			end
			if (positive)
				acc += int'(voice_gain[v]) * 32767;
			else
				acc -= int'(voice_gain[v]) * 32767;
		end
		acc = acc >>> MIX_SHIFT;
		return acc[SAMPLE_W-1:0];
	endfunction

	// Track register writes, check results, then predict from accepted requests
	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_W-1:0] wanted;
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				voice_phase[v] = '0;
				voice_step[v]  = '0;
				voice_gain[v]  = '0;
			end
			play_on = 1'b0;
			due_samples.delete();
			mismatch_count = 0;
			samples_due    = 0;
		end else begin
			if (cfg_wr_en)
				play_on = cfg_wr_data;

			// result side: oldest expectation first
			if (rsp_valid && !rsp_stall) begin
				if (due_samples.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: sample %0d with no request outstanding",
							$realtime, sample);
				end else begin
					wanted = due_samples.pop_front();
					if (sample !== wanted) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: sample mismatch, expected %0d got %0d",
								$realtime, wanted, sample);
					end
				end
			end

			// request side
			if (req_valid && !req_stall) begin
				case (action)
				ACT_SET_VOICE: begin
					if (channel < VOICES) begin
						voice_gain[channel] = volume;
						voice_step[channel] = freq_step[15:1];
					end
				end
				ACT_SAMPLE: begin
					// disabled: no output and phases hold
					if (play_on) begin
						due_samples.push_back(mix_voices());
						for (int v = 0; v < VOICES; v++)
							voice_phase[v] = voice_phase[v] + PHASE_W'(voice_step[v]);
					end
				end
				ACT_SILENCE: begin
					// phases kept
					for (int v = 0; v < VOICES; v++) begin
						voice_step[v] = '0;
						voice_gain[v] = '0;
					end
				end
				default: ;
				endcase
			end

			samples_due = due_samples.size();
		end
	end

endmodule

### tb/six_voice_wavetable_mixer_top_tb.sv
// Testbench top for the six-voice wavetable mixer: clock, reset, request stimulus,
// output stall pattern and verdict. Depends on smx_pkg, the block's top level
// and six_voice_wavetable_mixer_checker.
`timescale 1ns / 100ps

module six_voice_wavetable_mixer_top_tb;
	import smx_pkg::*;

	// Action code the block leaves unused
	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam int         HOLD_CYCLES = 200;
	localparam int         SETTLE      = 12;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        req_valid   = 1'b0;
	logic        req_stall;
	logic [1:0]  action      = '0;
	logic [2:0]  channel     = '0;
	logic [15:0] freq_step   = '0;
	logic [7:0]  volume      = '0;
	logic        rsp_valid;
	logic        rsp_stall   = 1'b0;
	logic signed [15:0] sample;

	int mismatch_count;
	int samples_due;
	int burst_left = 0;
	int hold_req   = 0;
	bit play_on    = 1'b0;

	six_voice_wavetable_mixer_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.channel    (channel),
		.freq_step  (freq_step),
		.volume     (volume),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.sample     (sample)
	);

	six_voice_wavetable_mixer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.action        (action),
		.channel       (channel),
		.freq_step     (freq_step),
		.volume        (volume),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.sample        (sample),
		.mismatch_count(mismatch_count),
		.samples_due   (samples_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Generous overall limit
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// Output stall pattern cycling through four modes, plus long hold-offs on demand
	initial begin : responder
		int hold_left;
		int hold_seen;
		int cyc;
		hold_left = 0;
		hold_seen = 0;
		cyc       = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				case ((cyc / 97) % 4)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= ((cyc % 7) < 3);
				endcase
			end
		end
	end

	// Present one request in bursts, holding it until accepted
	task automatic offer(input logic [1:0] act, input logic [2:0] ch,
		input logic [15:0] fs, input logic [7:0] vol);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_valid <= 1'b1;
		action    <= act;
		channel   <= ch;
		freq_step <= fs;
		volume    <= vol;
		do @(posedge clk); while (req_stall);
	endtask

	// Stop requesting until every sample is back and the block has settled
	task automatic drain();
		req_valid  <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (samples_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_play_enable(input logic value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		play_on     = value;
	endtask

	// One random request; mostly voice setup and samples
	task automatic random_request(output bit counted);
		int          pick;
		logic [1:0]  act;
		logic [2:0]  ch;
		logic [15:0] fs;
		pick = $urandom_range(0, 99);
		ch   = 3'($urandom_range(0, 7));
		fs   = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 3) == 0)
			fs = 16'($urandom_range(0, 1023));
		if (pick < 50)
			act = ACT_SAMPLE;
		else if (pick < 90)
			act = ACT_SET_VOICE;
		else if (pick < 95)
			act = ACT_SILENCE;
		else
			act = ACT_UNUSED;
		offer(act, ch, fs, 8'($urandom_range(0, 255)));
		case (act)
		ACT_SAMPLE:    counted = play_on;
		ACT_SET_VOICE: counted = (ch < VOICES);
		ACT_SILENCE:   counted = 1'b1;
		default:       counted = 1'b0;
		endcase
	endtask

	task automatic random_phase(input int target, input int pause_at);
		int done;
		bit counted;
		done = 0;
		while (done < target) begin
			random_request(counted);
			if (counted) begin
				done++;
				if (done == pause_at)
					drain();
			end
		end
	endtask

	// Main stimulus
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_play_enable(1'b0);

		// disabled: no output, phases must not move
		offer(ACT_SAMPLE, 3'd0, 16'h0000, 8'h00);
		for (int v = 0; v < SQUARE_VOICES; v++)
			offer(ACT_SET_VOICE, 3'(v), 16'h4000, 8'hFF);
		for (int v = SQUARE_VOICES; v < VOICES; v++)
			offer(ACT_SET_VOICE, 3'(v), 16'h0000, 8'hFF);
		// out-of-range voices and the unused code are ignored
		offer(ACT_SET_VOICE, 3'd6, 16'hFFFF, 8'hFF);
		offer(ACT_SET_VOICE, 3'd7, 16'hFFFF, 8'hFF);
		offer(ACT_UNUSED, 3'd7, 16'hFFFF, 8'hFF);
		offer(ACT_SAMPLE, 3'd7, 16'hFFFF, 8'hFF);
		drain();
		write_play_enable(1'b1);

		// zero mix, then every voice at full negative scale
		offer(ACT_SAMPLE, 3'd0, 16'h0000, 8'h00);
		offer(ACT_SAMPLE, 3'd0, 16'h0000, 8'h00);
		offer(ACT_SET_VOICE, 3'd0, 16'hFFFF, 8'h80);
		offer(ACT_SET_VOICE, 3'd4, 16'h0001, 8'h01);
		offer(ACT_SET_VOICE, 3'd5, 16'hAAAA, 8'h7F);
		repeat (3) offer(ACT_SAMPLE, 3'd0, 16'h0000, 8'h00);
		// silence keeps phases but mutes everything
		offer(ACT_SILENCE, 3'd0, 16'h0000, 8'h00);
		offer(ACT_SAMPLE, 3'd0, 16'h0000, 8'h00);
		offer(ACT_SET_VOICE, 3'd3, 16'h5555, 8'hFF);
		repeat (2) offer(ACT_SAMPLE, 3'd0, 16'h0000, 8'h00);

		// random, enabled, with a full pause half way
		random_phase(250, 125);
		drain();
		write_play_enable(1'b0);
		random_phase(40, 0);
		drain();
		write_play_enable(1'b1);

		// long output hold-off while samples keep coming
		hold_req++;
		burst_left = 40;
		repeat (40) offer(ACT_SAMPLE, 3'd0, 16'h0000, 8'h00);
		random_phase(230, 0);

		drain();
		if (mismatch_count == 0 && samples_due == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
